FILE: hdl/cdq_pkg.sv
// Package for the circular deque: sizes, request codes, request/result structs
// and the controller-to-datapath command struct. No dependencies.
`default_nettype none

package cdq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_REAR  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_REAR   = 3'd3;
  localparam logic [2:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [2:0] REQ_PEEK_REAR  = 3'd5;

  typedef struct packed {
    logic [2:0]                   req_type;
    logic signed [DATA_WIDTH-1:0] value;
  } cdq_req_t;

  typedef struct packed {
    logic                         ok;
    logic signed [DATA_WIDTH-1:0] data;
    logic                         is_empty;
    logic                         is_full;
  } cdq_rsp_t;

  typedef struct packed {
    logic load;  // capture the request
    logic exec;  // update indices, access the ring store
    logic done;  // present the result
  } cdq_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/cdq_ctrl.sv
// Controller for the circular deque: sequences accept, execute and result.
// Depends on cdq_pkg.
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output logic          busy_o,
  output cdq_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = (state_q == ST_EXEC);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // next request may be taken while the result is out
        state_d = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.load = accept;
  assign cmd_o.exec = (state_q == ST_EXEC);
  assign cmd_o.done = (state_q == ST_DONE);

endmodule

`default_nettype wire

FILE: hdl/cdq_datapath.sv
// Datapath for the circular deque: request register, head/tail/count, ring
// store with registered read, and result registers. Depends on cdq_pkg.
`default_nettype none

module cdq_datapath
  import cdq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cdq_cmd_t cmd_i,
  input  wire cdq_req_t req_i,
  output cdq_rsp_t      rsp_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  cdq_req_t              req_q;
  logic [IDX_W-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  ok_q, ok_d;
  logic                  rd_sel_q, rd_sel_d;
  logic [DATA_WIDTH-1:0] fill_q, fill_d;
  logic                  empty_q, full_q;
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  wr_en;
  logic [IDX_W-1:0]      addr;
  logic                  is_empty_now, is_full_now;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign is_empty_now = (cnt_q == '0);
  assign is_full_now  = (cnt_q == CNT_W'(DEPTH));

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    ok_d     = 1'b0;
    rd_sel_d = 1'b0;
    fill_d   = '0;
    wr_en    = 1'b0;
    addr     = head_q;
    case (req_q.req_type) inside
      REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
        if (!is_full_now) begin
          wr_en = 1'b1;
          ok_d  = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (is_empty_now) begin
            head_d = '0;
            tail_d = '0;
            addr   = '0;
          end else if (req_q.req_type == REQ_PUSH_FRONT) begin
            head_d = wrap_dec(head_q);
            addr   = head_d;
          end else begin
            tail_d = wrap_inc(tail_q);
            addr   = tail_d;
          end
        end
      end
      REQ_POP_FRONT, REQ_POP_REAR, REQ_PEEK_FRONT, REQ_PEEK_REAR: begin
        if (is_empty_now) begin
          fill_d = '1;
        end else begin
          ok_d     = 1'b1;
          rd_sel_d = 1'b1;
          if (req_q.req_type == REQ_POP_FRONT || req_q.req_type == REQ_PEEK_FRONT) begin
            addr = head_q;
          end else begin
            addr = tail_q;
          end
          if (req_q.req_type == REQ_POP_FRONT) begin
            head_d = wrap_inc(head_q);
            cnt_d  = cnt_q - 1'b1;
          end else if (req_q.req_type == REQ_POP_REAR) begin
            tail_d = wrap_dec(tail_q);
            cnt_d  = cnt_q - 1'b1;
          end
        end
      end
      default: begin
        // undefined codes leave the state alone
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      empty_q <= 1'b1;
      full_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      empty_q <= (cnt_d == '0);
      full_q  <= (cnt_d == CNT_W'(DEPTH));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      ok_q     <= ok_d;
      rd_sel_q <= rd_sel_d;
      fill_q   <= fill_d;
    end
  end

  // ring store: one write or one registered read per request
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[addr] <= req_q.value;
    end
    if (cmd_i.exec) begin
      rd_data_q <= mem[addr];
    end
  end

  always_comb begin
    rsp_o.ok       = ok_q && cmd_i.done;
    rsp_o.data     = rd_sel_q ? rd_data_q : fill_q;
    rsp_o.is_empty = empty_q;
    rsp_o.is_full  = full_q;
  end

endmodule

`default_nettype wire

FILE: hdl/circular_deque.sv
// Circular deque, 16 words of 32 bits. A taken request passes through ST_EXEC
// and then ST_DONE; done_o is high in ST_DONE, when the result is to be taken.
// The execute state holds busy, and the next request is taken while a result
// is out.
// Reset clears head, tail and count; the ring store is not cleared.
// The receiver cannot stall: done_o marks a result for exactly one cycle.
// Top level: ties cdq_ctrl and cdq_datapath together. Depends on cdq_pkg.
`default_nettype none

module circular_deque
  import cdq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output logic          busy_o,
  input  wire cdq_req_t req_i,
  output logic          done_o,
  output cdq_rsp_t      rsp_o
);

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  cdq_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

  assign done_o = cmd.done;

endmodule

`default_nettype wire
